FILE: rtl/core/thdc_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the thermostat delay/hysteresis core
// no dependencies
package thdc_pkg;

   // regulation mode codes
   localparam logic [1:0] MODE_OFF  = 2'd0;
   localparam logic [1:0] MODE_HEAT = 2'd1;
   localparam logic [1:0] MODE_COOL = 2'd2;
   localparam logic [1:0] MODE_RSVD = 2'd3;

   // csr register indexes
   localparam int unsigned CsrIdxW = 3;
   localparam logic [CsrIdxW-1:0] CSR_HEAT_MODE  = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_FAN_MODE   = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_USE_REMOTE = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_ON_DELAY   = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_OFF_DELAY  = 3'd4;

   localparam int unsigned TimeW = 32;
   localparam int unsigned TempW = 8;

   // configuration seen by the datapath
   typedef struct packed {
      logic [1:0]       heat_mode;
      logic             fan_mode;
      logic             use_remote;
      logic [TimeW-1:0] on_delay;
      logic [TimeW-1:0] off_delay;
   } cfg_type;

   // drive states after one tick
   typedef struct packed {
      logic heat;
      logic cool;
   } drive_type;

endpackage

FILE: rtl/core/thermostat_delay_hysteresis_control_core.sv
`timescale 1ns / 1ps
// thermostat with switch-on/switch-off delays
// a request passes the input register, then the result register, before its response is valid
// throughput: one transaction per cycle unless a stalled response (rsp_ready low) holds the stages
// drive state is updated as an item leaves the input stage
// reset: synchronous, active high; clears drives, timer, configuration and both stage valids
// depends on thdc_pkg, thdc_csr, thdc_regulate
module thermostat_delay_hysteresis_control_core (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [thdc_pkg::TimeW-1:0]    req_now_ms,
   input  logic [thdc_pkg::TempW-1:0]    req_local_temp,
   input  logic [thdc_pkg::TempW-1:0]    req_remote_temp,
   input  logic [thdc_pkg::TempW-1:0]    req_target_temp,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_heat_on,
   output logic                          rsp_cool_on,
   output logic                          rsp_fan_on,
   output logic [thdc_pkg::TempW-1:0]    rsp_current_temp,
   // configuration
   input  logic                          csr_write_en,
   input  logic [thdc_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [thdc_pkg::TimeW-1:0]    csr_wdata
);
   import thdc_pkg::*;

   cfg_type cfg;

   // input stage
   logic             in_valid_ff;
   logic             in_valid_in;
   logic [TimeW-1:0] now_ff;
   logic [TempW-1:0] local_ff;
   logic [TempW-1:0] remote_ff;
   logic [TempW-1:0] target_ff;

   // result stage
   logic             out_valid_ff;
   logic             out_valid_in;
   logic             heat_ff;
   logic             cool_ff;
   logic             fan_ff;
   logic [TempW-1:0] temp_ff;

   logic             advance;
   logic             req_fire;
   logic [TempW-1:0] cur_temp;
   drive_type        drive_next;

   thdc_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   // stage handshake
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   assign in_valid_in  = req_fire || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   // sensor select
   assign cur_temp = cfg.use_remote ? remote_ff : local_ff;

   thdc_regulate u_regulate (
      .clock       (clock),
      .reset       (reset),
      .fire        (advance),
      .cfg         (cfg),
      .now_ms      (now_ff),
      .cur_temp    (cur_temp),
      .target_temp (target_ff),
      .drive_next  (drive_next)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // input payload capture
   always_ff @(posedge clock) begin
      if (req_fire) begin
         now_ff    <= req_now_ms;
         local_ff  <= req_local_temp;
         remote_ff <= req_remote_temp;
         target_ff <= req_target_temp;
      end
   end

   // result payload capture
   always_ff @(posedge clock) begin
      if (advance) begin
         heat_ff <= drive_next.heat;
         cool_ff <= drive_next.cool;
         fan_ff  <= cfg.fan_mode || drive_next.heat || drive_next.cool;
         temp_ff <= cur_temp;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_heat_on      = heat_ff;
   assign rsp_cool_on      = cool_ff;
   assign rsp_fan_on       = fan_ff;
   assign rsp_current_temp = temp_ff;

`ifndef SYNTHESIS
   // fan follows any running drive
   a_fan_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_heat_on || rsp_cool_on)) |-> rsp_fan_on)
      else $error("fan off while a drive is on");

   // an empty result stage never blocks the input stage
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !out_valid_ff |-> req_ready)
      else $error("request stalled with empty result stage");

   // a held item that leaves the input stage lands in the result stage
   a_advance_lands: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("transaction lost between stages");
`endif

endmodule

FILE: rtl/core/thdc_csr.sv
`timescale 1ns / 1ps
// configuration register file: write-only, no wait states
// depends on thdc_pkg
module thdc_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_en,
   input  logic [thdc_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [thdc_pkg::TimeW-1:0]    csr_wdata,
   output thdc_pkg::cfg_type             cfg
);
   import thdc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // register decode; reserved mode code and unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_HEAT_MODE: begin
               if (csr_wdata[1:0] != MODE_RSVD) cfg_in.heat_mode = csr_wdata[1:0];
            end
            CSR_FAN_MODE:   cfg_in.fan_mode   = csr_wdata[0];
            CSR_USE_REMOTE: cfg_in.use_remote = csr_wdata[0];
            CSR_ON_DELAY:   cfg_in.on_delay   = csr_wdata;
            CSR_OFF_DELAY:  cfg_in.off_delay  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/core/thdc_regulate.sv
`timescale 1ns / 1ps
// drive state and switch-delay timer, updated once per transaction
// depends on thdc_pkg
module thdc_regulate (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        fire,
   input  thdc_pkg::cfg_type           cfg,
   input  logic [thdc_pkg::TimeW-1:0]  now_ms,
   input  logic [thdc_pkg::TempW-1:0]  cur_temp,
   input  logic [thdc_pkg::TempW-1:0]  target_temp,
   output thdc_pkg::drive_type         drive_next
);
   import thdc_pkg::*;

   drive_type        drive_ff;
   drive_type        drive_in;
   logic [TimeW-1:0] last_cross_ff;
   logic [TimeW-1:0] last_cross_in;

   logic             is_heat;
   logic             active;
   logic             drive_cur;
   logic             below;
   logic             above;
   logic             want_switch;
   logic [TimeW-1:0] elapsed;
   logic [TimeW-1:0] delay_sel;
   logic             drive_new;

   // pick the regulated drive and its pending switch condition
   always_comb begin
      is_heat     = (cfg.heat_mode == MODE_HEAT);
      active      = is_heat || (cfg.heat_mode == MODE_COOL);
      drive_cur   = is_heat ? drive_ff.heat : drive_ff.cool;
      below       = (cur_temp < target_temp);
      above       = (cur_temp > target_temp);
      // heat switches on below target, cool switches on above
      want_switch = (drive_cur ^ is_heat) ? below : above;
      elapsed     = now_ms - last_cross_ff;
      delay_sel   = drive_cur ? cfg.off_delay : cfg.on_delay;
      drive_new   = (want_switch && (elapsed > delay_sel)) ? !drive_cur : drive_cur;
   end

   // next state; off mode holds everything
   always_comb begin
      drive_in      = drive_ff;
      last_cross_in = last_cross_ff;
      if (active) begin
         if (!want_switch) last_cross_in = now_ms;
         if (is_heat) drive_in.heat = drive_new;
         else         drive_in.cool = drive_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drive_ff      <= '0;
         last_cross_ff <= '0;
      end else if (fire) begin
         drive_ff      <= drive_in;
         last_cross_ff <= last_cross_in;
      end
   end

   assign drive_next = drive_in;

`ifndef SYNTHESIS
   // off mode leaves drives and timer alone
   a_off_holds: assert property (@(posedge clock) disable iff (reset)
      (fire && cfg.heat_mode == MODE_OFF) |=> $stable(drive_ff) && $stable(last_cross_ff))
      else $error("state changed in off mode");

   // heat mode never touches the cooler, and the reverse
   a_heat_keeps_cool: assert property (@(posedge clock) disable iff (reset)
      (fire && cfg.heat_mode == MODE_HEAT) |=> $stable(drive_ff.cool))
      else $error("cooler changed in heat mode");

   a_cool_keeps_heat: assert property (@(posedge clock) disable iff (reset)
      (fire && cfg.heat_mode == MODE_COOL) |=> $stable(drive_ff.heat))
      else $error("heater changed in cool mode");

   // a drive that switched had its timer running, so the timer did not restart
   a_switch_no_restart: assert property (@(posedge clock) disable iff (reset)
      (fire && active && (drive_new != drive_cur)) |=> $stable(last_cross_ff))
      else $error("timer restarted on a switching tick");
`endif

endmodule
